// ===== design/hng_pkg.sv =====
package hng_pkg;

	// Register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SAMPLES   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEFF  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_GAIN     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD_LEN  = 3'd6;

	// Fixed field widths
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned HYST_W  = 12;
	localparam int unsigned HOLD_W  = 15;
	localparam int unsigned COEFF_W = 16;
	localparam int unsigned GAIN_W  = 17;
	localparam int unsigned LA_W    = 11;

	// Unity in Q1.16, kept at gain width
	localparam logic [GAIN_W-1:0] UNITY = 17'h10000;

	// Register values after reset
	localparam logic [LEVEL_W-1:0] RST_OPEN_THRESHOLD = 16'hE200;
	localparam logic [HYST_W-1:0]  RST_HYSTERESIS     = 12'd768;
	localparam logic [HOLD_W-1:0]  RST_HOLD_SAMPLES   = 15'd2400;
	localparam logic [COEFF_W-1:0] RST_ATTACK_COEFF   = 16'd65263;
	localparam logic [COEFF_W-1:0] RST_RELEASE_COEFF  = 16'd65522;
	localparam logic [GAIN_W-1:0]  RST_RANGE_GAIN     = 17'd0;
	localparam logic [LA_W-1:0]    RST_LOOKAHEAD_LEN  = 11'd0;

	typedef struct packed {
		logic [LEVEL_W-1:0] open_threshold;
		logic [HYST_W-1:0]  hysteresis;
		logic [HOLD_W-1:0]  hold_samples;
		logic [COEFF_W-1:0] attack_coeff;
		logic [COEFF_W-1:0] release_coeff;
		logic [GAIN_W-1:0]  range_gain;
		logic [LA_W-1:0]    lookahead_len;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic env_step;
		logic gain_step;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_busy;
	} ctrl_status_t;

endpackage

// ===== design/hng_cfg.sv =====
module hng_cfg #(
	parameter int unsigned MAX_LOOKAHEAD = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hng_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hng_pkg::CFG_DATA_W-1:0] cfg_data,
	output hng_pkg::cfg_t                  cfg,
	output logic                           la_restart
);
	import hng_pkg::*;

	localparam logic [LA_W-1:0] LA_CAP = (MAX_LOOKAHEAD > 2047) ? 11'h7FF : LA_W'(MAX_LOOKAHEAD);

	cfg_t             cfg_q;
	logic             wr;
	logic [GAIN_W-1:0] range_sat;
	logic [LA_W-1:0]  la_sat;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;
	assign cfg = cfg_q;

	// Clamp range to unity and lookahead to the delay depth
	always_comb begin
		range_sat = (cfg_data[GAIN_W-1:0] > UNITY) ? UNITY : cfg_data[GAIN_W-1:0];
		la_sat = (cfg_data[LA_W-1:0] > LA_CAP) ? LA_CAP : cfg_data[LA_W-1:0];
	end

	// Restart the delay position when the lookahead length really changes
	assign la_restart = wr && (cfg_index == CFG_LOOKAHEAD_LEN) && (la_sat != cfg_q.lookahead_len);

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_threshold <= RST_OPEN_THRESHOLD;
			cfg_q.hysteresis     <= RST_HYSTERESIS;
			cfg_q.hold_samples   <= RST_HOLD_SAMPLES;
			cfg_q.attack_coeff   <= RST_ATTACK_COEFF;
			cfg_q.release_coeff  <= RST_RELEASE_COEFF;
			cfg_q.range_gain     <= RST_RANGE_GAIN;
			cfg_q.lookahead_len  <= RST_LOOKAHEAD_LEN;
		end else if (wr) begin
			case (cfg_index)
				CFG_OPEN_THRESHOLD: cfg_q.open_threshold <= cfg_data[LEVEL_W-1:0];
				CFG_HYSTERESIS:     cfg_q.hysteresis     <= cfg_data[HYST_W-1:0];
				CFG_HOLD_SAMPLES:   cfg_q.hold_samples   <= cfg_data[HOLD_W-1:0];
				CFG_ATTACK_COEFF:   cfg_q.attack_coeff   <= cfg_data[COEFF_W-1:0];
				CFG_RELEASE_COEFF:  cfg_q.release_coeff  <= cfg_data[COEFF_W-1:0];
				CFG_RANGE_GAIN:     cfg_q.range_gain     <= range_sat;
				CFG_LOOKAHEAD_LEN:  cfg_q.lookahead_len  <= la_sat;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/hng_ctrl.sv =====
module hng_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hng_pkg::ctrl_status_t status,
	output hng_pkg::ctrl_cmd_t    cmd
);
	import hng_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ENV  = 2'd1;
	localparam logic [1:0] ST_GAIN = 2'd2;
	localparam logic [1:0] ST_MUL  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;

	assign in_ready = (state_q == ST_IDLE);

	// Sequence one frame: gate, envelope, gain, sample multiply
	always_comb begin
		cmd = '0;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_next = ST_ENV;
				end
			end
			ST_ENV: begin
				cmd.env_step = 1'b1;
				state_next = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.gain_step = 1'b1;
				state_next = ST_MUL;
			end
			ST_MUL: begin
				// Hold until the output register can take the result
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ===== design/hng_dp.sv =====
module hng_dp #(
	parameter int unsigned SAMPLE_BITS   = 24,
	parameter int unsigned MAX_LOOKAHEAD = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hng_pkg::cfg_t               cfg,
	input  logic                        la_restart,
	input  hng_pkg::ctrl_cmd_t          cmd,
	output hng_pkg::ctrl_status_t       status,
	input  logic [SAMPLE_BITS-1:0]      in_left,
	input  logic [SAMPLE_BITS-1:0]      in_right,
	input  logic                        in_level_valid,
	input  logic [hng_pkg::LEVEL_W-1:0] in_level,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [SAMPLE_BITS-1:0]      out_left,
	output logic [SAMPLE_BITS-1:0]      out_right,
	output logic                        out_gate
);
	import hng_pkg::*;

	localparam int unsigned AW = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
	localparam int unsigned FW = $clog2(MAX_LOOKAHEAD + 1);
	localparam int unsigned SB = SAMPLE_BITS;

	// Frame state
	logic              gate_open_q;
	logic [HOLD_W-1:0] hold_q;
	logic [GAIN_W-1:0] env_q;
	logic [GAIN_W-1:0] gain_q;
	logic [SB-1:0]     sample_l_q;
	logic [SB-1:0]     sample_r_q;

	// Delay line
	logic [2*SB-1:0] delay_mem [MAX_LOOKAHEAD];
	logic [2*SB-1:0] rd_data_q;
	logic            rd_valid_q;
	logic [AW-1:0]   delay_pos_q;
	logic [FW-1:0]   fill_q;
	logic [AW-1:0]   p_q;
	logic [AW-1:0]   rd_addr;
	logic [31:0]     pos_inc;
	logic            la_on;
	logic            mem_we;

	// Output register
	logic          out_valid_q;
	logic [SB-1:0] out_left_q;
	logic [SB-1:0] out_right_q;
	logic          out_gate_q;

	// Gate decision
	logic signed [LEVEL_W+1:0] thr_base;
	logic signed [LEVEL_W+1:0] thr;
	logic signed [LEVEL_W+1:0] lvl_ext;
	logic                      trig;
	logic                      close;

	// Envelope and gain
	logic [GAIN_W-1:0]     target;
	logic                  attack;
	logic [GAIN_W-1:0]     env_diff;
	logic [COEFF_W-1:0]    env_coeff;
	logic [GAIN_W+COEFF_W-1:0] env_prod;
	logic [GAIN_W-1:0]     env_q16;
	logic [2*GAIN_W-1:0]   gain_prod;

	// Sample multiply
	logic [SB-1:0]           src_l;
	logic [SB-1:0]           src_r;
	logic signed [SB+17:0]   prod_l;
	logic signed [SB+17:0]   prod_r;

	assign la_on = (cfg.lookahead_len != '0);

	// Compare the level against the open or the close threshold
	always_comb begin
		thr_base = $signed({{2{cfg.open_threshold[LEVEL_W-1]}}, cfg.open_threshold});
		thr = gate_open_q ? (thr_base - $signed({6'b0, cfg.hysteresis})) : thr_base;
		lvl_ext = $signed({{2{in_level[LEVEL_W-1]}}, in_level});
		trig = in_level_valid && (lvl_ext >= thr);
		close = in_level_valid && !(lvl_ext >= thr) && (hold_q == '0);
	end

	// Update gate and hold on acceptance, and the envelope in a later step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_open_q <= 1'b0;
			hold_q <= '0;
			env_q <= '0;
		end else begin
			if (cmd.accept) begin
				if (trig) begin
					gate_open_q <= 1'b1;
				end else if (close) begin
					gate_open_q <= 1'b0;
				end
				if (trig) begin
					hold_q <= cfg.hold_samples;
				end else if (hold_q != '0) begin
					hold_q <= hold_q - HOLD_W'(1);
				end
			end
			if (cmd.env_step && (attack || hold_q == '0)) begin
				env_q <= attack ? (target - env_q16) : (target + env_q16);
			end
		end
	end

	// One-pole envelope toward the gate target
	always_comb begin
		target = gate_open_q ? UNITY : '0;
		attack = target > env_q;
		env_diff = attack ? (target - env_q) : (env_q - target);
		env_coeff = attack ? cfg.attack_coeff : cfg.release_coeff;
		env_prod = {{COEFF_W{1'b0}}, env_diff} * {{GAIN_W{1'b0}}, env_coeff};
		env_q16 = env_prod[GAIN_W+COEFF_W-1:COEFF_W];
		gain_prod = {{GAIN_W{1'b0}}, UNITY - cfg.range_gain} * {{GAIN_W{1'b0}}, env_q};
	end

	// Latch the frame and blend range to unity by the envelope
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_l_q <= in_left;
			sample_r_q <= in_right;
		end
		if (cmd.gain_step) begin
			gain_q <= cfg.range_gain + gain_prod[2*GAIN_W-2:COEFF_W];
		end
	end

	// Delay line read address and write-back
	always_comb begin
		rd_addr = (32'(delay_pos_q) < 32'(cfg.lookahead_len)) ? delay_pos_q : '0;
		pos_inc = 32'(p_q) + 32'd1;
		mem_we = cmd.env_step && la_on;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			delay_mem[p_q] <= {sample_r_q, sample_l_q};
		end
		if (cmd.accept) begin
			rd_data_q <= delay_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			p_q <= rd_addr;
			rd_valid_q <= 32'(rd_addr) < 32'(fill_q);
		end
	end

	// Advance the position; the fill count marks entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_pos_q <= '0;
			fill_q <= '0;
		end else begin
			if (la_restart) begin
				delay_pos_q <= '0;
			end else if (mem_we) begin
				delay_pos_q <= (pos_inc >= 32'(cfg.lookahead_len)) ? '0 : AW'(pos_inc);
			end
			if (mem_we && (pos_inc > 32'(fill_q))) begin
				fill_q <= FW'(pos_inc);
			end
		end
	end

	// Apply gain, floor by the shift
	always_comb begin
		src_l = la_on ? (rd_valid_q ? rd_data_q[SB-1:0] : '0) : sample_l_q;
		src_r = la_on ? (rd_valid_q ? rd_data_q[2*SB-1:SB] : '0) : sample_r_q;
		prod_l = $signed({{18{src_l[SB-1]}}, src_l}) * $signed({{(SB+1){1'b0}}, gain_q});
		prod_r = $signed({{18{src_r[SB-1]}}, src_r}) * $signed({{(SB+1){1'b0}}, gain_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_left_q <= prod_l[SB+15:16];
			out_right_q <= prod_r[SB+15:16];
			out_gate_q <= gate_open_q;
		end
	end

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_left = out_left_q;
	assign out_right = out_right_q;
	assign out_gate = out_gate_q;

endmodule

// ===== design/hysteresis_noise_gate.sv =====
// After acceptance the sequencer steps through its envelope, gain and multiply states;
// m_tvalid rises once the output register loads, which waits while a result is held.
// The three registered multiplies (envelope, gain, sample) run in turn; no new frame is taken until the chain is done.
// Reset: arst_n clears control state, envelope, gate, hold and delay position
// and loads register defaults; the delay memory is not swept, a fill count makes
// never-written entries read as zero.
module hysteresis_noise_gate #(
	parameter int unsigned SAMPLE_BITS   = 24,
	parameter int unsigned MAX_LOOKAHEAD = 1024
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	// sample_left, sample_right, level_db (zero padded to bytes)
	input  logic [((2*SAMPLE_BITS+16+7)/8)*8-1:0]           s_tdata,
	// level_valid
	input  logic                                            s_tuser,
	input  logic                                            s_tvalid,
	output logic                                            s_tready,
	// out_left, out_right (zero padded to bytes)
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]              m_tdata,
	// gate_is_open
	output logic                                            m_tuser,
	output logic                                            m_tvalid,
	input  logic                                            m_tready,
	input  logic                                            cfg_valid,
	output logic                                            cfg_ready,
	input  logic [hng_pkg::CFG_IDX_W-1:0]                   cfg_index,
	input  logic [hng_pkg::CFG_DATA_W-1:0]                  cfg_data
);
	import hng_pkg::*;

	localparam int unsigned SB = SAMPLE_BITS;
	localparam int unsigned OUT_W = ((2*SAMPLE_BITS+7)/8)*8;

	cfg_t           cfg;
	logic           la_restart;
	ctrl_cmd_t      cmd;
	ctrl_status_t   status;
	logic [SB-1:0]  out_left;
	logic [SB-1:0]  out_right;

	hng_cfg #(
		.MAX_LOOKAHEAD(MAX_LOOKAHEAD)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg),
		.la_restart(la_restart)
	);

	hng_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.status(status),
		.cmd(cmd)
	);

	hng_dp #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_LOOKAHEAD(MAX_LOOKAHEAD)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.la_restart(la_restart),
		.cmd(cmd),
		.status(status),
		.in_left(s_tdata[SB-1:0]),
		.in_right(s_tdata[2*SB-1:SB]),
		.in_level_valid(s_tuser),
		.in_level(s_tdata[2*SB+LEVEL_W-1:2*SB]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_left(out_left),
		.out_right(out_right),
		.out_gate(m_tuser)
	);

	// Pack the result with the left sample lowest
	assign m_tdata = OUT_W'({out_right, out_left});

endmodule

// ===== tb/hysteresis_noise_gate_tb.sv =====
`timescale 1ns / 100ps

module hysteresis_noise_gate_tb;
	import hng_pkg::*;

	localparam int SAMPLE_BITS   = 24;
	localparam int MAX_LOOKAHEAD = 1024;
	localparam int unsigned GAIN_ONE = UNITY;
	localparam int QUIET_LIMIT   = 3000;
	localparam int PRESSURE_AT   = 400;
	localparam int PRESSURE_LEN  = 300;
	localparam int PHASES        = 12;
	localparam int PHASE_FRAMES  = 110;
	localparam int REPORT_MAX    = 10;
	localparam int LEVEL_MIN     = -24576;
	localparam int LEVEL_MAX     = 3071;

	// Index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] S_MIN = -24'sd8388608;

	typedef struct packed {
		logic signed [23:0] left;
		logic signed [23:0] right;
		logic               lv;
		logic signed [15:0] level;
	} frame_t;

	typedef struct packed {
		logic signed [23:0] left;
		logic signed [23:0] right;
		logic               open;
	} result_t;

	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [16:0]          data;
		frame_t               f;
		logic                 has_exp;
		result_t              e;
	} row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic [63:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Typed expectation riding along with a directed request
	logic    dir_has_exp = 1'b0;
	result_t dir_exp     = '0;

	// Idle control
	logic tx_idle_on  = 1'b0;
	logic rx_idle_on  = 1'b0;
	logic tail_quiet  = 1'b0;

	// Gate model state and register shadow
	int          open_thr;
	int unsigned hyst_db, hold_len, atk_coeff, rel_coeff, rng_gain, la_len;
	int unsigned envelope_q, hold_cnt, dly_pos;
	bit          gate_open;
	logic signed [23:0] dly_l [MAX_LOOKAHEAD];
	logic signed [23:0] dly_r [MAX_LOOKAHEAD];

	result_t gated_out_q [$];
	row_t    directed_rows [$];

	int mismatches = 0;
	int frames_in = 0, frames_out = 0, reg_writes = 0;
	int gate_opens = 0, gate_closes = 0;
	int quiet_cycles = 0;
	int rx_count = 0, stall_left = 0;
	bit pressure_done = 0;

	always #6 clk = ~clk;

	hysteresis_noise_gate #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.MAX_LOOKAHEAD(MAX_LOOKAHEAD)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Floor of sample times Q1.16 gain
	function automatic logic [23:0] scale_sample(input logic signed [23:0] s,
			input int unsigned g);
		longint prod;
		prod = longint'(s) * longint'(g);
		return prod[39:16];
	endfunction

	// Update the register shadow for one accepted write
	function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [16:0] data);
		int unsigned v;
		case (idx)
			CFG_OPEN_THRESHOLD: open_thr = int'($signed(data[15:0]));
			CFG_HYSTERESIS:     hyst_db = data[11:0];
			CFG_HOLD_SAMPLES:   hold_len = data[14:0];
			CFG_ATTACK_COEFF:   atk_coeff = data[15:0];
			CFG_RELEASE_COEFF:  rel_coeff = data[15:0];
			CFG_RANGE_GAIN: begin
				v = data;
				rng_gain = (v > GAIN_ONE) ? GAIN_ONE : v;
			end
			CFG_LOOKAHEAD_LEN: begin
				v = data[10:0];
				if (v > MAX_LOOKAHEAD)
					v = MAX_LOOKAHEAD;
				if (v != la_len) begin
					la_len = v;
					dly_pos = 0;
				end
			end
			default: ;
		endcase
	endfunction

	// Gate decision, hold, envelope, gain, delay and multiply for one frame
	function automatic result_t gate_frame(input frame_t f);
		result_t r;
		bit reloaded;
		int unsigned tgt, gain, p;
		longint d;
		logic signed [23:0] sl, sr;
		reloaded = 0;
		if (f.lv) begin
			if (int'(f.level) >= (gate_open ? open_thr - int'(hyst_db) : open_thr)) begin
				gate_open = 1;
				hold_cnt = hold_len;
				reloaded = 1;
			end else if (hold_cnt == 0) begin
				gate_open = 0;
			end
		end
		if (!reloaded && hold_cnt > 0)
			hold_cnt--;

		tgt = gate_open ? GAIN_ONE : 0;
		if (tgt > envelope_q) begin
			d = (longint'(tgt - envelope_q) * longint'(atk_coeff)) >> 16;
			envelope_q = tgt - 32'(d);
		end else if (hold_cnt == 0) begin
			d = (longint'(envelope_q - tgt) * longint'(rel_coeff)) >> 16;
			envelope_q = tgt + 32'(d);
		end

		d = (longint'(GAIN_ONE - rng_gain) * longint'(envelope_q)) >> 16;
		gain = rng_gain + 32'(d);

		sl = f.left;
		sr = f.right;
		if (la_len > 0) begin
			p = (dly_pos < la_len) ? dly_pos : 0;
			sl = dly_l[p];
			sr = dly_r[p];
			dly_l[p] = f.left;
			dly_r[p] = f.right;
			p++;
			dly_pos = (p >= la_len) ? 0 : p;
		end
		r.left = scale_sample(sl, gain);
		r.right = scale_sample(sr, gain);
		r.open = gate_open;
		return r;
	endfunction

	// Track writes and requests, predict, and check output frames
	always @(posedge clk) begin
		frame_t  f;
		result_t want, got;
		bit      was_open;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_setting(cfg_index, cfg_data);
				reg_writes++;
			end
			if (s_tvalid && s_tready) begin
				f.left = s_tdata[23:0];
				f.right = s_tdata[47:24];
				f.level = s_tdata[63:48];
				f.lv = s_tuser;
				was_open = gate_open;
				want = gate_frame(f);
				if (!was_open && gate_open)
					gate_opens++;
				if (was_open && !gate_open)
					gate_closes++;
				if (dir_has_exp)
					want = dir_exp;
				gated_out_q.push_back(want);
				frames_in++;
			end
			if (m_tvalid && m_tready) begin
				got.left = m_tdata[23:0];
				got.right = m_tdata[47:24];
				got.open = m_tuser;
				if (gated_out_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("output frame %0d with nothing outstanding: L=%0d R=%0d open=%0b",
							frames_out, got.left, got.right, got.open);
				end else begin
					want = gated_out_q.pop_front();
					if (got.left !== want.left || got.right !== want.right ||
							got.open !== want.open) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("frame %0d: expected L=%0d R=%0d open=%0b, got L=%0d R=%0d open=%0b",
								frames_out, want.left, want.right, want.open,
								got.left, got.right, got.open);
					end
				end
				frames_out++;
			end
		end
	end

	// Output side: random stalls, one long hold-off, always ready at the tail
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				rx_count <= rx_count + 1;
			if (tail_quiet) begin
				m_tready <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready <= (stall_left == 1);
			end else if (!pressure_done && rx_count >= PRESSURE_AT) begin
				pressure_done <= 1;
				stall_left <= PRESSURE_LEN;
				m_tready <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(1, 6);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Abort when no channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d idle cycles", quiet_cycles);
				$display("hysteresis_noise_gate: mismatch");
				$finish;
			end
		end
	end

	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] data);
		row_t r;
		r = '0;
		r.is_cfg = 1;
		r.idx = idx;
		r.data = data;
		directed_rows.push_back(r);
	endtask

	task automatic add_frame(input logic signed [23:0] l, input logic signed [23:0] rr,
			input logic lv, input int level, input logic has_exp,
			input logic signed [23:0] el, input logic signed [23:0] er, input logic eo);
		row_t r;
		r = '0;
		r.f.left = l;
		r.f.right = rr;
		r.f.lv = lv;
		r.f.level = 16'(level);
		r.has_exp = has_exp;
		r.e.left = el;
		r.e.right = er;
		r.e.open = eo;
		directed_rows.push_back(r);
	endtask

	// Hold the request until the block takes it; valid stays high afterwards
	task automatic send_frame(input frame_t f, input logic has_exp, input result_t e);
		s_tdata <= {f.level, f.right, f.left};
		s_tuser <= f.lv;
		s_tvalid <= 1'b1;
		dir_has_exp <= has_exp;
		dir_exp <= e;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drop valid and wait until every frame has come out
	task automatic quiesce();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (gated_out_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [16:0] pick_value(input int lo, input int hi, input int typ_hi);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 17'(lo);
		if (r == 1)
			return 17'(hi);
		if (r == 2)
			return 17'($urandom());
		return 17'(lo + int'($urandom_range(0, typ_hi - lo)));
	endfunction

	function automatic logic signed [23:0] pick_sample();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom_range(0, 1) ? S_MAX : S_MIN;
		if (r == 1)
			return 24'(int'($urandom_range(0, 511)) - 256);
		return 24'($urandom());
	endfunction

	// Levels cluster around the open and close thresholds
	function automatic int pick_level(input int thr, input int hyst);
		int v;
		if ($urandom_range(0, 5) == 0)
			return LEVEL_MIN + int'($urandom_range(0, LEVEL_MAX - LEVEL_MIN));
		v = thr + int'($urandom_range(0, hyst + 1024)) - hyst - 512;
		if (v < LEVEL_MIN)
			v = LEVEL_MIN;
		if (v > LEVEL_MAX)
			v = LEVEL_MAX;
		return v;
	endfunction

	initial begin
		row_t    row;
		frame_t  f;
		result_t none;
		bit      prev_cfg;
		int      thr_p, hyst_p, lv_every;
		logic [16:0] thr_v, hyst_v, hold_v, atk_v, rel_v, rng_v, la_v;

		// Model state after reset
		open_thr = int'($signed(RST_OPEN_THRESHOLD));
		hyst_db = RST_HYSTERESIS;
		hold_len = RST_HOLD_SAMPLES;
		atk_coeff = RST_ATTACK_COEFF;
		rel_coeff = RST_RELEASE_COEFF;
		rng_gain = RST_RANGE_GAIN;
		la_len = RST_LOOKAHEAD_LEN;
		envelope_q = 0;
		gate_open = 0;
		hold_cnt = 0;
		dly_pos = 0;
		for (int i = 0; i < MAX_LOOKAHEAD; i++) begin
			dly_l[i] = '0;
			dly_r[i] = '0;
		end
		none = '0;

		// Closed gate at reset settings: muted below the threshold, then a level at it opens the gate
		add_frame(S_MAX, S_MIN, 0, 0, 1, 0, 0, 0);
		add_frame(S_MIN, S_MAX, 1, LEVEL_MIN, 1, 0, 0, 0);
		add_frame(-1, 1, 1, -7681, 1, 0, 0, 0);
		add_frame(12345, -54321, 1, -7680, 0, 0, 0, 0);
		// Unity range: samples pass untouched, gate flag visible
		add_cfg(CFG_RANGE_GAIN, 17'(GAIN_ONE));
		add_frame(S_MAX, S_MIN, 1, LEVEL_MAX, 1, S_MAX, S_MIN, 1);
		add_frame(-1, 1, 1, -8448, 1, -1, 1, 1);
		add_frame(100, -100, 1, -8449, 1, 100, -100, 1);
		add_cfg(CFG_HOLD_SAMPLES, 17'd0);
		add_frame(5, 6, 1, 0, 1, 5, 6, 1);
		add_frame(7, 8, 1, -8449, 1, 7, 8, 0);
		// Range above unity saturates; unused index changes nothing
		add_cfg(CFG_RANGE_GAIN, 17'h1FFFF);
		add_frame(S_MIN, S_MAX, 0, 0, 1, S_MIN, S_MAX, 0);
		add_cfg(CFG_UNUSED, 17'd0);
		add_frame(S_MAX, -1, 0, 0, 1, S_MAX, -1, 0);
		// Lookahead beyond the maximum, then a change back to one frame
		add_cfg(CFG_LOOKAHEAD_LEN, 17'd2047);
		add_frame(1000, 2000, 0, 0, 1, 0, 0, 0);
		add_cfg(CFG_LOOKAHEAD_LEN, 17'd1);
		add_frame(3, 4, 0, 0, 0, 0, 0, 0);
		add_frame(9, 10, 0, 0, 0, 0, 0, 0);
		// Instant attack, slowest release, widest hysteresis, top threshold
		add_cfg(CFG_LOOKAHEAD_LEN, 17'd0);
		add_cfg(CFG_RANGE_GAIN, 17'd32768);
		add_cfg(CFG_ATTACK_COEFF, 17'd0);
		add_cfg(CFG_RELEASE_COEFF, 17'd65535);
		add_cfg(CFG_HYSTERESIS, 17'd3072);
		add_cfg(CFG_OPEN_THRESHOLD, 17'd0);
		add_frame(S_MAX, S_MIN, 1, 0, 0, 0, 0, 0);
		add_frame(S_MAX, S_MIN, 1, -3073, 0, 0, 0, 0);
		add_frame(S_MIN, S_MAX, 1, -3072, 0, 0, 0, 0);
		add_cfg(CFG_RELEASE_COEFF, 17'd0);
		add_frame(-1, 1, 0, 0, 0, 0, 0, 0);
		add_cfg(CFG_OPEN_THRESHOLD, 17'(LEVEL_MIN));
		add_frame(-3, 3, 1, LEVEL_MIN, 0, 0, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		prev_cfg = 0;
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				if (!prev_cfg)
					quiesce();
				write_reg(row.idx, row.data);
				prev_cfg = 1;
			end else begin
				if (prev_cfg)
					cfg_valid <= 1'b0;
				send_frame(row.f, row.has_exp, row.e);
				prev_cfg = 0;
			end
		end

		// Random phases, each under its own settings
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				thr_v = 17'(LEVEL_MIN); hyst_v = 0; hold_v = 0;
				atk_v = 0; rel_v = 0; rng_v = 0; la_v = 0;
			end else if (ph == 1) begin
				thr_v = 0; hyst_v = 3072; hold_v = 32767;
				atk_v = 65535; rel_v = 65535; rng_v = 17'(GAIN_ONE);
				la_v = 17'(MAX_LOOKAHEAD);
			end else begin
				thr_v = pick_value(LEVEL_MIN, 0, 0);
				hyst_v = pick_value(0, 3072, 3072);
				hold_v = pick_value(0, 32767, 48);
				atk_v = pick_value(0, 65535, 65535);
				rel_v = pick_value(0, 65535, 65535);
				rng_v = pick_value(0, GAIN_ONE, GAIN_ONE);
				la_v = pick_value(0, MAX_LOOKAHEAD, 12);
			end
			thr_p = int'($signed(thr_v[15:0]));
			hyst_p = int'(hyst_v[11:0]);
			lv_every = (ph % 4 == 3) ? 1 : 4;

			quiesce();
			write_reg(CFG_OPEN_THRESHOLD, thr_v);
			write_reg(CFG_HYSTERESIS, hyst_v);
			write_reg(CFG_HOLD_SAMPLES, hold_v);
			write_reg(CFG_ATTACK_COEFF, atk_v);
			write_reg(CFG_RELEASE_COEFF, rel_v);
			write_reg(CFG_RANGE_GAIN, rng_v);
			write_reg(CFG_LOOKAHEAD_LEN, la_v);
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_UNUSED, 17'($urandom()));
			cfg_valid <= 1'b0;

			tx_idle_on = (ph % 3 != 2) && (ph != PHASES - 1);
			rx_idle_on <= (ph % 3 != 1) && (ph != PHASES - 1);
			tail_quiet <= (ph == PHASES - 1);

			for (int n = 0; n < PHASE_FRAMES; n++) begin
				f.left = pick_sample();
				f.right = pick_sample();
				f.lv = ($urandom_range(1, lv_every) == 1);
				f.level = 16'(pick_level(thr_p, hyst_p));
				send_frame(f, 0, none);
				if (tx_idle_on && $urandom_range(0, 4) == 0) begin
					s_tvalid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
			end
		end

		// Drain and report
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (gated_out_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		mismatches += gated_out_q.size();

		$display("run: %0d frames in, %0d out, %0d register writes over %0d random settings",
			frames_in, frames_out, reg_writes, PHASES);
		$display("run: gate opened %0d times, closed %0d times, %0d mismatches",
			gate_opens, gate_closes, mismatches);
		if (mismatches == 0)
			$display("hysteresis_noise_gate: match");
		else
			$display("hysteresis_noise_gate: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/hng_pkg.sv
design/hng_cfg.sv
design/hng_ctrl.sv
design/hng_dp.sv
design/hysteresis_noise_gate.sv
tb/hysteresis_noise_gate_tb.sv
